// ===== src/ubd_pkg.sv =====
// ----------------------------------------------------------------------------
// ubd_pkg
// Shared types, status codes and baud rate table for the divisor block
// ----------------------------------------------------------------------------
package ubd_pkg;

  localparam int unsigned NumRates = 21;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned FracSteps = 7;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_BAUD   = 3'd1,
    ST_WORD   = 3'd2,
    ST_PARITY = 3'd3,
    ST_STOP   = 3'd4
  } status_e;

  localparam logic [6:0] FifoEnable = 7'h10;

  typedef struct packed {
    status_e     status;
    logic [6:0]  lcr;
    logic [31:0] clk;
    logic [19:0] baud;
    logic [23:0] span;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [22:0] idiv;
    logic [6:0]  fdiv;
    logic [6:0]  lcr;
  } res_t;

  function automatic logic [19:0] rate_lookup(input logic [4:0] code);
    logic [19:0] r;
    unique case (code)
      5'd0:    r = 20'd50;
      5'd1:    r = 20'd75;
      5'd2:    r = 20'd110;
      5'd3:    r = 20'd134;
      5'd4:    r = 20'd200;
      5'd5:    r = 20'd300;
      5'd6:    r = 20'd600;
      5'd7:    r = 20'd1200;
      5'd8:    r = 20'd1800;
      5'd9:    r = 20'd2400;
      5'd10:   r = 20'd4800;
      5'd11:   r = 20'd9600;
      5'd12:   r = 20'd19200;
      5'd13:   r = 20'd38400;
      5'd14:   r = 20'd57600;
      5'd15:   r = 20'd76800;
      5'd16:   r = 20'd115200;
      5'd17:   r = 20'd230400;
      5'd18:   r = 20'd380400;
      5'd19:   r = 20'd460800;
      5'd20:   r = 20'd921600;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/ubd_fifo.sv =====
// ----------------------------------------------------------------------------
// ubd_fifo
// Small register queue with full and empty flags
// ----------------------------------------------------------------------------
module ubd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== src/ubd_front.sv =====
// ----------------------------------------------------------------------------
// ubd_front
// Checks the codes, looks up the baud rate and packs the line control word
// ----------------------------------------------------------------------------
module ubd_front (
  input  logic [31:0]   clock_rate_i,
  input  logic [4:0]    baud_code_i,
  input  logic [2:0]    word_length_code_i,
  input  logic [1:0]    parity_code_i,
  input  logic [1:0]    stop_code_i,
  output ubd_pkg::req_t req_o
);

  logic [1:0]  pbits;
  logic        sbit;
  logic [19:0] baud;

  assign baud = ubd_pkg::rate_lookup(baud_code_i);

  always_comb begin
    case (parity_code_i)
      2'd1:    pbits = 2'd2;
      2'd2:    pbits = 2'd1;
      default: pbits = 2'd0;
    endcase
    sbit = (stop_code_i == 2'd2);

    req_o.clk    = clock_rate_i;
    req_o.baud   = baud;
    req_o.span   = {baud, 4'b0};
    req_o.lcr    = ubd_pkg::FifoEnable | {word_length_code_i[1:0], 1'b0, sbit, pbits, 1'b0};
    req_o.status = ubd_pkg::ST_OK;
    if (baud_code_i >= 5'(ubd_pkg::NumRates)) begin
      req_o.status = ubd_pkg::ST_BAUD;
    end else if (word_length_code_i > 3'd3) begin
      req_o.status = ubd_pkg::ST_WORD;
    end else if (parity_code_i == 2'd3) begin
      req_o.status = ubd_pkg::ST_PARITY;
    end else if (stop_code_i == 2'd1 || stop_code_i == 2'd3) begin
      req_o.status = ubd_pkg::ST_STOP;
    end
  end

endmodule

// ===== src/ubd_back.sv =====
// ----------------------------------------------------------------------------
// ubd_back
// Bit-per-stage divider pipeline for the integer and fractional divisors
// ----------------------------------------------------------------------------
module ubd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  ubd_pkg::req_t in_req_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  output ubd_pkg::res_t out_res_o,
  input  logic          out_ready_i
);

  localparam int unsigned NSteps = ubd_pkg::DivSteps + ubd_pkg::FracSteps;
  localparam int unsigned NStages = NSteps + 1;

  typedef struct packed {
    ubd_pkg::status_e status;
    logic [6:0]       lcr;
    logic [31:0]      bits;
    logic [19:0]      baud;
    logic [23:0]      span;
    logic [23:0]      r;
    logic [22:0]      q;
    logic [6:0]       t;
  } stage_t;

  stage_t pipe_q [NStages];
  stage_t pipe_d [NStages];
  logic [NStages-1:0] vld_q;
  logic en;
  logic [6:0] t_last;

  function automatic stage_t step(input stage_t s, input int unsigned k);
    stage_t o;
    logic [24:0] rr;
    logic [23:0] src_r;
    logic [31:0] src_b;
    o = s;
    if (k < ubd_pkg::DivSteps) begin
      rr = {s.r, s.bits[31]};
      o.bits = {s.bits[30:0], 1'b0};
      if (rr >= {1'b0, s.span}) begin
        rr = rr - {1'b0, s.span};
        o.q = {s.q[21:0], 1'b1};
      end else begin
        o.q = {s.q[21:0], 1'b0};
      end
      o.r = rr[23:0];
    end else begin
      if (k == ubd_pkg::DivSteps) begin
        src_r = {4'b0, s.r[23:4]};
        src_b = {s.r[3:0], 28'b0};
      end else begin
        src_r = s.r;
        src_b = s.bits;
      end
      rr = {src_r, src_b[31]};
      o.bits = {src_b[30:0], 1'b0};
      if (rr >= {5'b0, s.baud}) begin
        rr = rr - {5'b0, s.baud};
        o.t = {s.t[5:0], 1'b1};
      end else begin
        o.t = {s.t[5:0], 1'b0};
      end
      o.r = rr[23:0];
    end
    return o;
  endfunction

  assign en = !(vld_q[NStages-1] && !out_ready_i);
  assign in_ready_o = en;

  always_comb begin
    pipe_d[0].status = in_req_i.status;
    pipe_d[0].lcr    = in_req_i.lcr;
    pipe_d[0].bits   = in_req_i.clk;
    pipe_d[0].baud   = in_req_i.baud;
    pipe_d[0].span   = in_req_i.span;
    pipe_d[0].r      = '0;
    pipe_d[0].q      = '0;
    pipe_d[0].t      = '0;
    for (int unsigned k = 1; k < NStages; k++) begin
      pipe_d[k] = step(pipe_q[k-1], k - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NStages-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int unsigned k = 0; k < NStages; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
    end
  end

  // round half up
  assign t_last = pipe_q[NStages-1].t;

  always_comb begin
    out_valid_o = vld_q[NStages-1];
    out_res_o.status = pipe_q[NStages-1].status;
    if (pipe_q[NStages-1].status == ubd_pkg::ST_OK) begin
      out_res_o.idiv = pipe_q[NStages-1].q;
      out_res_o.fdiv = {1'b0, t_last[6:1]} + {6'b0, t_last[0]};
      out_res_o.lcr  = pipe_q[NStages-1].lcr;
    end else begin
      out_res_o.idiv = '0;
      out_res_o.fdiv = '0;
      out_res_o.lcr  = '0;
    end
  end

endmodule

// ===== src/uart_baud_divisor_and_line_control_top.sv =====
// ----------------------------------------------------------------------------
// uart_baud_divisor_and_line_control_top
// UART baud divisor and line control word former
// ----------------------------------------------------------------------------
// Requests enter through a queue port: drive the fields and push while full
// is low. Each request gives one result, read through a queue port: the
// oldest result is on the result ports while empty is low and leaves on pop.
// The front checks the codes and packs the line control word into a two-beat
// queue. The back is a divider pipeline of 39 steps, one quotient bit per
// stage: 32 for the integer divisor, 7 for the 128ths that are rounded to
// 64ths. One beat is accepted per cycle unless a full output queue holds the
// pipeline.
// Reset empties both queues and the pipeline. When the receiver stops
// popping, the output queue fills, the pipeline holds, the input queue fills
// and full rises; nothing is dropped.
// ----------------------------------------------------------------------------
module uart_baud_divisor_and_line_control_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] clock_rate_i,
  input  logic [4:0]  baud_code_i,
  input  logic [2:0]  word_length_code_i,
  input  logic [1:0]  parity_code_i,
  input  logic [1:0]  stop_code_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  status_o,
  output logic [22:0] integer_divisor_o,
  output logic [6:0]  fractional_divisor_o,
  output logic [6:0]  line_control_o
);

  ubd_pkg::req_t req, mid_req;
  ubd_pkg::res_t res, out_res;
  logic mid_empty, back_ready, back_valid, out_full;

  ubd_front u_front (
    .clock_rate_i       (clock_rate_i),
    .baud_code_i        (baud_code_i),
    .word_length_code_i (word_length_code_i),
    .parity_code_i      (parity_code_i),
    .stop_code_i        (stop_code_i),
    .req_o              (req)
  );

  ubd_fifo #(.Width($bits(ubd_pkg::req_t)), .Depth(2)) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (req),
    .full_o  (full),
    .pop_i   (back_ready),
    .rdata_o (mid_req),
    .empty_o (mid_empty)
  );

  ubd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!mid_empty),
    .in_req_i    (mid_req),
    .in_ready_o  (back_ready),
    .out_valid_o (back_valid),
    .out_res_o   (res),
    .out_ready_i (!out_full)
  );

  ubd_fifo #(.Width($bits(ubd_pkg::res_t)), .Depth(2)) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid),
    .wdata_i (res),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_res),
    .empty_o (empty)
  );

  assign status_o             = out_res.status;
  assign integer_divisor_o    = out_res.idiv;
  assign fractional_divisor_o = out_res.fdiv;
  assign line_control_o       = out_res.lcr;

endmodule
